@@ sv/lss_pkg.sv @@
// shared constants and types for the laplacian stencil stream
package lss_pkg;

  // default sizes
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // configuration register widths and port sizes
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 12;
  localparam int CFG_DATA_BITS   = 12;
  localparam int CFG_IDX_BITS    = 1;
  localparam int ROW_BITS        = 12;

  // reset values and smallest frame dimension
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam int MIN_DIM          = 3;

  // extra bits so the four-neighbour sum never overflows
  localparam int LAP_GROWTH = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // position flags carried along with each pixel
  typedef struct packed {
    logic interior;
    logic last;
  } pos_flags_t;

endpackage

@@ sv/lss_position.sv @@
// frame geometry registers and raster position counters
module lss_position import lss_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COL_BITS  = $clog2(MAX_WIDTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     advance_i,
  output logic [COL_BITS-1:0]      col_o,
  output logic [ROW_BITS-1:0]      row_o,
  output pos_flags_t               flags_o
);

  localparam int WIDTH_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;

  logic [COL_BITS-1:0]        wlast_q, wlast_d;
  logic [ROW_BITS-1:0]        hlast_q, hlast_d;
  logic [COL_BITS-1:0]        col_q, col_d;
  logic [ROW_BITS-1:0]        row_q, row_d;
  logic [WIDTH_REG_BITS-1:0]  w_raw;
  logic [HEIGHT_REG_BITS-1:0] h_raw;

  assign w_raw = cfg_wdata_i[WIDTH_REG_BITS-1:0];
  assign h_raw = cfg_wdata_i[HEIGHT_REG_BITS-1:0];

  // clamp the written dimensions and keep them as last index
  always_comb begin
    if (w_raw < WIDTH_REG_BITS'(MIN_DIM)) begin
      wlast_d = COL_BITS'(MIN_DIM - 1);
    end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
      wlast_d = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      wlast_d = COL_BITS'(w_raw - WIDTH_REG_BITS'(1));
    end
    if (h_raw < HEIGHT_REG_BITS'(MIN_DIM)) begin
      hlast_d = ROW_BITS'(MIN_DIM - 1);
    end else begin
      hlast_d = ROW_BITS'(h_raw - HEIGHT_REG_BITS'(1));
    end
  end

  // raster walk with wrap at row and frame end
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + ROW_BITS'(1);
      end else begin
        col_d = col_q + COL_BITS'(1);
      end
    end
  end

  // geometry registers and counters, a write restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= COL_BITS'(WIDTH_RST - 1);
      hlast_q <= ROW_BITS'(FRAME_HEIGHT_RST - 1);
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  wlast_q <= wlast_d;
        REG_FRAME_HEIGHT: hlast_q <= hlast_d;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o            = col_q;
  assign row_o            = row_q;
  assign flags_o.interior = (row_q >= ROW_BITS'(2)) && (col_q >= COL_BITS'(2));
  assign flags_o.last     = (row_q == hlast_q) && (col_q == wlast_q);

endmodule

@@ sv/lss_line_store.sv @@
// two line memories holding the two rows above the incoming one
module lss_line_store import lss_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COL_BITS    = $clog2(MAX_WIDTH)
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [COL_BITS-1:0]    rd_addr_i,
  input  logic [SAMPLE_BITS-1:0] mid_wdata_i,
  input  logic                   up_we_i,
  input  logic [COL_BITS-1:0]    up_waddr_i,
  input  logic [SAMPLE_BITS-1:0] up_wdata_i,
  output logic [SAMPLE_BITS-1:0] up_rdata_o,
  output logic [SAMPLE_BITS-1:0] mid_rdata_o
);

  logic [SAMPLE_BITS-1:0] up_mem  [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] mid_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] up_rd_q;
  logic [SAMPLE_BITS-1:0] mid_rd_q;

  // middle line: read old entry and store the new sample in one access
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mid_rd_q           <= mid_mem[rd_addr_i];
      mid_mem[rd_addr_i] <= mid_wdata_i;
    end
  end

  // upper line: write-back trails the read by one column, never the same entry
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_q <= up_mem[rd_addr_i];
    end
    if (up_we_i) begin
      up_mem[up_waddr_i] <= up_wdata_i;
    end
  end

  assign up_rdata_o  = up_rd_q;
  assign mid_rdata_o = mid_rd_q;

endmodule

@@ sv/lss_kernel.sv @@
// stencil window, laplacian sum and output register
module lss_kernel import lss_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COL_BITS    = $clog2(MAX_WIDTH),
  parameter int LAP_BITS    = SAMPLE_BITS + LAP_GROWTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  input  logic [COL_BITS-1:0]        col_i,
  input  logic [ROW_BITS-1:0]        row_i,
  input  pos_flags_t                 flags_i,
  input  logic [SAMPLE_BITS-1:0]     up_rdata_i,
  input  logic [SAMPLE_BITS-1:0]     mid_rdata_i,
  input  logic                       out_stall_i,
  output logic                       advance_o,
  output logic                       up_we_o,
  output logic [COL_BITS-1:0]        up_waddr_o,
  output logic [SAMPLE_BITS-1:0]     up_wdata_o,
  output logic                       out_valid_o,
  output logic signed [LAP_BITS-1:0] lap_value_o,
  output logic [COL_BITS-1:0]        center_col_o,
  output logic [ROW_BITS-1:0]        center_row_o,
  output logic                       frame_last_o
);

  // read stage registers
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic [COL_BITS-1:0]    s1_col_q;
  logic [ROW_BITS-1:0]    s1_row_q;
  pos_flags_t             s1_flags_q;

  // window registers
  logic [SAMPLE_BITS-1:0] up_prev_q;
  logic [SAMPLE_BITS-1:0] mid_prev_q;
  logic [SAMPLE_BITS-1:0] mid_prev2_q;
  logic [SAMPLE_BITS-1:0] prev_sample_q;

  // output register
  logic                       out_valid_q;
  logic signed [LAP_BITS-1:0] lap_q;
  logic [COL_BITS-1:0]        ccol_q;
  logic [ROW_BITS-1:0]        crow_q;
  logic                       last_q;

  logic                       s1_move;
  logic signed [LAP_BITS-1:0] lap_d;

  // whole pipeline moves unless a result is held back
  assign advance_o = !out_valid_q || !out_stall_i;
  assign s1_move   = s1_valid_q && advance_o;

  // middle entry moves up to the upper line once the item leaves
  assign up_we_o    = s1_move;
  assign up_waddr_o = s1_col_q;
  assign up_wdata_o = mid_rdata_i;

  // left + right + up + down - 4 * centre, exact width
  assign lap_d = {{LAP_GROWTH{mid_prev2_q[SAMPLE_BITS-1]}}, mid_prev2_q}
               + {{LAP_GROWTH{mid_rdata_i[SAMPLE_BITS-1]}}, mid_rdata_i}
               + {{LAP_GROWTH{up_prev_q[SAMPLE_BITS-1]}}, up_prev_q}
               + {{LAP_GROWTH{prev_sample_q[SAMPLE_BITS-1]}}, prev_sample_q}
               - {mid_prev_q[SAMPLE_BITS-1], mid_prev_q, 2'b00};

  // read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance_o) begin
      s1_valid_q <= accept_i;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_sample_q <= sample_i;
      s1_col_q    <= col_i;
      s1_row_q    <= row_i;
      s1_flags_q  <= flags_i;
    end
  end

  // window shifts by one column per item
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      up_prev_q     <= up_rdata_i;
      mid_prev2_q   <= mid_prev_q;
      mid_prev_q    <= mid_rdata_i;
      prev_sample_q <= s1_sample_q;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= s1_valid_q && s1_flags_q.interior;
    end
  end

  // output payload for interior pixels
  always_ff @(posedge clk_i) begin
    if (s1_move && s1_flags_q.interior) begin
      lap_q  <= lap_d;
      ccol_q <= s1_col_q - COL_BITS'(1);
      crow_q <= s1_row_q - ROW_BITS'(1);
      last_q <= s1_flags_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lap_value_o  = lap_q;
  assign center_col_o = ccol_q;
  assign center_row_o = crow_q;
  assign frame_last_o = last_q;

endmodule

@@ sv/laplacian_stencil_stream.sv @@
// top level of the streaming 4-neighbour laplacian filter
// sample below-right of a centre: read stage, then its result in the output register
// rate: one sample per cycle unless stalled, one read-and-write per line memory per cycle
// the output register decouples the sides: input stalls only while a result is held back
// reset clears counters and frame size (640 x 480); line memories are not cleared
// a configuration write restarts the frame at row 0, column 0
module laplacian_stencil_stream import lss_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]             cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS+LAP_GROWTH-1:0] lap_value_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        center_col_o,
  output logic [ROW_BITS-1:0]                 center_row_o,
  output logic                                frame_last_o
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic                   advance;
  logic                   accept;
  logic [COL_BITS-1:0]    col;
  logic [ROW_BITS-1:0]    row;
  pos_flags_t             flags;
  logic                   up_we;
  logic [COL_BITS-1:0]    up_waddr;
  logic [SAMPLE_BITS-1:0] up_wdata;
  logic [SAMPLE_BITS-1:0] up_rdata;
  logic [SAMPLE_BITS-1:0] mid_rdata;

  // input transaction
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  lss_position #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (accept),
    .col_o       (col),
    .row_o       (row),
    .flags_o     (flags)
  );

  lss_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line_store (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_addr_i   (col),
    .mid_wdata_i (sample_i),
    .up_we_i     (up_we),
    .up_waddr_i  (up_waddr),
    .up_wdata_i  (up_wdata),
    .up_rdata_o  (up_rdata),
    .mid_rdata_o (mid_rdata)
  );

  lss_kernel #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .sample_i     (sample_i),
    .col_i        (col),
    .row_i        (row),
    .flags_i      (flags),
    .up_rdata_i   (up_rdata),
    .mid_rdata_i  (mid_rdata),
    .out_stall_i  (out_stall_i),
    .advance_o    (advance),
    .up_we_o      (up_we),
    .up_waddr_o   (up_waddr),
    .up_wdata_o   (up_wdata),
    .out_valid_o  (out_valid_o),
    .lap_value_o  (lap_value_o),
    .center_col_o (center_col_o),
    .center_row_o (center_row_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ sv/lss_checker.sv @@
// port-level checks for the laplacian stencil stream, bound to the top level
module lss_port_checks import lss_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [SAMPLE_BITS+LAP_GROWTH-1:0] lap_value_o,
  input logic [$clog2(MAX_WIDTH)-1:0]        center_col_o,
  input logic [ROW_BITS-1:0]                 center_row_o,
  input logic                                frame_last_o
);

  // a held-back result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lap_value_o)
      && $stable(center_col_o) && $stable(center_row_o) && $stable(frame_last_o))
    else $error("held result changed");

  // input is stalled exactly while a result waits
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to waiting result");

  // results never on row 0 or column 0
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (center_col_o != '0) && (center_row_o != '0))
    else $error("result on a border coordinate");

  // the frame's last result is not directly followed by another
  a_frame_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_last_o |=> !out_valid_o)
    else $error("result right after end of frame");

endmodule

bind laplacian_stencil_stream lss_port_checks #(
  .MAX_WIDTH   (MAX_WIDTH),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lss_checker (.*);
